/* rtl/sip_pkg.sv */
// Package for the segment intersection pipeline: widths and the stage payload type.
package sip_pkg;
    localparam int FIELD_W = 16;
    localparam int DW      = 18;   // coordinate difference
    localparam int PW      = 36;   // product of two differences
    localparam int CW      = 37;   // cross or dot of differences
    localparam int NW      = 55;   // numerator tn * r
    localparam int QW      = 19;   // quotient magnitude bits
    localparam int SQW     = 33;   // sum of squares of the point
    localparam int RTW     = 17;   // square root result bits

    typedef struct packed {
        logic hit;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
    } t_point;
endpackage

/* rtl/segment_intersection_point.sv */
// Top level: segment intersection point and origin distance, fully pipelined.
//
// channel | ports                                   | handshake
// in      | i_first_*, i_second_* (16 bit signed)   | i_start & !o_busy
// out     | o_hit, o_cross_x, o_cross_y, o_origin_distance | o_done, one cycle
//
// One item per cycle; the pipeline has 5 arithmetic stages, 19 divider stages,
// 1 square stage, 17 root stages and 1 output register.
// o_busy is always low: the receiver cannot stall and nothing waits.
// Reset clears the valid bits only; payload registers run free.
module segment_intersection_point import sip_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic signed [FIELD_W-1:0] i_first_start_x,
    input  logic signed [FIELD_W-1:0] i_first_start_y,
    input  logic signed [FIELD_W-1:0] i_first_end_x,
    input  logic signed [FIELD_W-1:0] i_first_end_y,
    input  logic signed [FIELD_W-1:0] i_second_start_x,
    input  logic signed [FIELD_W-1:0] i_second_start_y,
    input  logic signed [FIELD_W-1:0] i_second_end_x,
    input  logic signed [FIELD_W-1:0] i_second_end_y,
    output logic                      o_done,
    output logic                      o_hit,
    output logic signed [FIELD_W-1:0] o_cross_x,
    output logic signed [FIELD_W-1:0] o_cross_y,
    output logic [FIELD_W-1:0]        o_origin_distance
);
    localparam int EB  = (COORD_BITS < 8) ? 8 : ((COORD_BITS > 16) ? 16 : COORD_BITS);
    localparam int DIV_LAT  = QW;
    localparam int SQ_LAT   = RTW;
    localparam int PT_DELAY = DIV_LAT;          // payload around the dividers
    localparam int LAT      = 5 + DIV_LAT + 1 + SQ_LAT + 1;

    function automatic logic signed [FIELD_W-1:0] sx(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] m;
        m = FIELD_W'((17'd1 << EB) - 17'd1);
        return $signed(((v & m) ^ (FIELD_W'(1) << (EB - 1))) - (FIELD_W'(1) << (EB - 1)));
    endfunction

    assign o_busy = 1'b0;
    logic n_acc;
    assign n_acc = i_start && !o_busy;

    // ---- stage 1: differences
    logic              r_v1;
    logic signed [DW-1:0] r_rx, r_ry, r_sx, r_sy, r_ax, r_ay;
    logic signed [FIELD_W-1:0] r_px1, r_py1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= n_acc;
        r_px1 <= sx(i_first_start_x);
        r_py1 <= sx(i_first_start_y);
        r_rx  <= DW'(sx(i_first_end_x))    - DW'(sx(i_first_start_x));
        r_ry  <= DW'(sx(i_first_end_y))    - DW'(sx(i_first_start_y));
        r_sx  <= DW'(sx(i_second_end_x))   - DW'(sx(i_second_start_x));
        r_sy  <= DW'(sx(i_second_end_y))   - DW'(sx(i_second_start_y));
        r_ax  <= DW'(sx(i_second_start_x)) - DW'(sx(i_first_start_x));
        r_ay  <= DW'(sx(i_second_start_y)) - DW'(sx(i_first_start_y));
    end

    // ---- stage 2: products
    logic r_v2;
    logic signed [PW-1:0] r_rxsy, r_rysx, r_axry, r_ayrx, r_axsy, r_aysx;
    logic signed [PW-1:0] r_rxrx, r_ryry, r_axrx, r_ayry, r_sxrx, r_syry;
    logic signed [PW-1:0] r_sxsx, r_sysy, r_axsx, r_aysy;
    logic signed [DW-1:0] r_rx2, r_ry2;
    logic signed [FIELD_W-1:0] r_px2, r_py2;
    logic r_a0_2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_rxsy <= r_rx * r_sy;  r_rysx <= r_ry * r_sx;
        r_axry <= r_ax * r_ry;  r_ayrx <= r_ay * r_rx;
        r_axsy <= r_ax * r_sy;  r_aysx <= r_ay * r_sx;
        r_rxrx <= r_rx * r_rx;  r_ryry <= r_ry * r_ry;
        r_axrx <= r_ax * r_rx;  r_ayry <= r_ay * r_ry;
        r_sxrx <= r_sx * r_rx;  r_syry <= r_sy * r_ry;
        r_sxsx <= r_sx * r_sx;  r_sysy <= r_sy * r_sy;
        r_axsx <= r_ax * r_sx;  r_aysy <= r_ay * r_sy;
        r_rx2 <= r_rx;  r_ry2 <= r_ry;
        r_px2 <= r_px1; r_py2 <= r_py1;
        r_a0_2 <= (r_ax == '0) && (r_ay == '0);
    end

    // ---- stage 3: crosses and dots
    logic r_v3;
    logic signed [CW-1:0] r_d, r_ar, r_tn, r_rr, r_t0, r_sr, r_ss, r_as;
    logic signed [DW-1:0] r_rx3, r_ry3;
    logic signed [FIELD_W-1:0] r_px3, r_py3;
    logic r_a0_3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_d  <= CW'(r_rxsy) - CW'(r_rysx);
        r_ar <= CW'(r_axry) - CW'(r_ayrx);
        r_tn <= CW'(r_axsy) - CW'(r_aysx);
        r_rr <= CW'(r_rxrx) + CW'(r_ryry);
        r_t0 <= CW'(r_axrx) + CW'(r_ayry);
        r_sr <= CW'(r_sxrx) + CW'(r_syry);
        r_ss <= CW'(r_sxsx) + CW'(r_sysy);
        r_as <= CW'(r_axsx) + CW'(r_aysy);
        r_rx3 <= r_rx2; r_ry3 <= r_ry2;
        r_px3 <= r_px2; r_py3 <= r_py2;
        r_a0_3 <= r_a0_2;
    end

    // ---- stage 4: sign normalize, decide hit
    logic r_v4, r_hit4, r_div4;
    logic [CW-1:0] r_dabs;
    logic signed [CW-1:0] r_tn4;
    logic signed [DW-1:0] r_rx4, r_ry4;
    logic signed [FIELD_W-1:0] r_px4, r_py4;
    logic signed [CW-1:0] n_t1, n_nd, n_tn, n_un, n_v;
    logic n_hit, n_div;
    always_comb begin
        n_t1 = r_t0 + r_sr;
        n_nd = -r_d;
        n_tn = r_d[CW-1] ? -r_tn : r_tn;
        n_un = r_d[CW-1] ? -r_ar : r_ar;
        n_v  = -r_as;
        n_hit = 1'b0;
        n_div = 1'b0;
        if (r_d != '0) begin
            n_div = 1'b1;
            n_hit = !n_tn[CW-1] && !n_un[CW-1]
                    && (n_tn <= (r_d[CW-1] ? n_nd : r_d))
                    && (n_un <= (r_d[CW-1] ? n_nd : r_d));
        end else if (r_ar == '0) begin
            if (r_rr != '0) begin
                if (!r_sr[CW-1]) n_hit = (r_t0 <= 0) && (n_t1 >= 0);
                else             n_hit = (n_t1 <= 0) && (r_t0 >= 0);
            end else if (r_ss == '0) begin
                n_hit = r_a0_3;
            end else begin
                n_hit = (r_tn == '0) && !n_v[CW-1] && (n_v <= r_ss);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_hit4 <= n_hit;
        r_div4 <= n_div && n_hit;
        r_dabs <= r_d[CW-1] ? n_nd : r_d;
        r_tn4  <= n_tn;
        r_rx4 <= r_rx3; r_ry4 <= r_ry3;
        r_px4 <= r_px3; r_py4 <= r_py3;
    end

    // ---- stage 5: numerators tn*r as magnitudes
    logic r_v5;
    logic [NW-1:0] r_nx, r_ny;
    logic r_negx5, r_negy5;
    logic [CW-1:0] r_den5;
    t_point r_pt5;
    logic r_div5;
    logic [DW-1:0] n_arx, n_ary;
    always_comb begin
        n_arx = r_rx4[DW-1] ? DW'(-r_rx4) : DW'(r_rx4);
        n_ary = r_ry4[DW-1] ? DW'(-r_ry4) : DW'(r_ry4);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
        // tn is nonnegative when a divide is needed
        r_nx <= NW'(r_tn4[CW-2:0]) * NW'(n_arx);
        r_ny <= NW'(r_tn4[CW-2:0]) * NW'(n_ary);
        r_negx5 <= r_rx4[DW-1];
        r_negy5 <= r_ry4[DW-1];
        r_den5 <= (r_dabs == '0) ? CW'(1) : r_dabs;
        r_pt5.hit <= r_hit4;
        r_pt5.x   <= r_px4;
        r_pt5.y   <= r_py4;
        r_div5 <= r_div4;
    end

    logic [QW-1:0] n_qx, n_qy;
    sip_div #(.NUM_W(NW), .DEN_W(CW), .Q_W(QW)) u_divx (
        .i_clk(i_clk), .i_num(r_nx), .i_den(r_den5), .o_quo(n_qx));
    sip_div #(.NUM_W(NW), .DEN_W(CW), .Q_W(QW)) u_divy (
        .i_clk(i_clk), .i_num(r_ny), .i_den(r_den5), .o_quo(n_qy));

    // delay line beside the dividers
    logic   r_vd  [PT_DELAY];
    t_point r_ptd [PT_DELAY];
    logic   r_divd [PT_DELAY];
    logic   r_nxd [PT_DELAY];
    logic   r_nyd [PT_DELAY];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PT_DELAY; k++) begin
            if (!i_rst_n)    r_vd[k] <= 1'b0;
            else if (k == 0) r_vd[k] <= r_v5;
            else             r_vd[k] <= r_vd[k-1];
            r_ptd[k]  <= (k == 0) ? r_pt5   : r_ptd[k-1];
            r_divd[k] <= (k == 0) ? r_div5  : r_divd[k-1];
            r_nxd[k]  <= (k == 0) ? r_negx5 : r_nxd[k-1];
            r_nyd[k]  <= (k == 0) ? r_negy5 : r_nyd[k-1];
        end
    end

    // ---- point and its squared norm
    t_point n_pt;
    logic signed [QW:0] n_ox, n_oy;
    always_comb begin
        n_ox = r_nxd[PT_DELAY-1] ? -$signed({1'b0, n_qx}) : $signed({1'b0, n_qx});
        n_oy = r_nyd[PT_DELAY-1] ? -$signed({1'b0, n_qy}) : $signed({1'b0, n_qy});
        n_pt = r_ptd[PT_DELAY-1];
        if (!n_pt.hit) begin
            n_pt.x = '0;
            n_pt.y = '0;
        end else if (r_divd[PT_DELAY-1]) begin
            n_pt.x = FIELD_W'(n_pt.x + n_ox[FIELD_W-1:0]);
            n_pt.y = FIELD_W'(n_pt.y + n_oy[FIELD_W-1:0]);
        end
    end
    logic r_vs;
    t_point r_pts;
    logic [SQW-1:0] r_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vs <= 1'b0;
        else          r_vs <= r_vd[PT_DELAY-1];
        r_pts <= n_pt;
        r_sq  <= SQW'(32'(n_pt.x * n_pt.x)) + SQW'(32'(n_pt.y * n_pt.y));
    end

    logic [RTW-1:0] n_root;
    sip_sqrt u_sqrt (.i_clk(i_clk), .i_val(r_sq), .o_root(n_root));

    logic   r_vq  [SQ_LAT];
    t_point r_ptq [SQ_LAT];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_LAT; k++) begin
            if (!i_rst_n)    r_vq[k] <= 1'b0;
            else if (k == 0) r_vq[k] <= r_vs;
            else             r_vq[k] <= r_vq[k-1];
            r_ptq[k] <= (k == 0) ? r_pts : r_ptq[k-1];
        end
    end

    // ---- output register
    logic r_done;
    t_point r_out;
    logic [FIELD_W-1:0] r_dist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_vq[SQ_LAT-1];
        r_out  <= r_ptq[SQ_LAT-1];
        r_dist <= n_root[FIELD_W-1:0];
    end

    assign o_done            = r_done;
    assign o_hit             = r_out.hit;
    assign o_cross_x         = r_out.x;
    assign o_cross_y         = r_out.y;
    assign o_origin_distance = r_dist;

    logic [LAT-1:0] r_chk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_chk <= '0;
        else          r_chk <= {r_chk[LAT-2:0], n_acc};
    end

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == r_chk[LAT-1]) else $error("result strobe out of step");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_hit |-> o_cross_x == '0 && o_cross_y == '0 && o_origin_distance == '0)
        else $error("miss carries nonzero point");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_div4 |-> r_dabs != '0) else $error("divide by zero");
endmodule

/* rtl/sip_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
module sip_div import sip_pkg::*; #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 37,
    parameter int Q_W   = 19
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);
    // quotient is known to fit in Q_W bits
    localparam int RW = DEN_W + 1;
    logic [RW-1:0]    r_rem [Q_W+1];
    logic [NUM_W-1:0] r_num [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];

    always_comb begin
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_shift;
        logic [NUM_W-1:0] n_numd;
        // prefix of numerator down to the bit being decided
        always_comb begin
            n_numd  = r_num[k] >> (Q_W - 1 - k);
            n_shift = (k == 0) ? RW'(n_numd) : {r_rem[k][RW-2:0], n_numd[0]};
            n_trial = n_shift - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            r_num[k+1] <= r_num[k];
            r_den[k+1] <= r_den[k];
            if (!n_trial[RW-1]) begin
                r_rem[k+1] <= n_trial;
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_shift;
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[Q_W];
endmodule

/* rtl/sip_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module sip_sqrt import sip_pkg::*; (
    input  logic           i_clk,
    input  logic [SQW-1:0] i_val,
    output logic [RTW-1:0] o_root
);
    localparam int RW = SQW + 2;
    logic [RW-1:0]  r_rem  [RTW+1];
    logic [RTW-1:0] r_root [RTW+1];
    logic [SQW-1:0] r_val  [RTW+1];

    always_comb begin
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_val[0]  = i_val;
    end

    for (genvar k = 0; k < RTW; k++) begin : g_step
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_trial;
        logic [1:0]    n_pair;
        always_comb begin
            n_pair  = 2'((34'(r_val[k]) >> (2 * (RTW - 1 - k))) & 34'd3);
            n_rem   = {r_rem[k][RW-3:0], n_pair};
            n_trial = n_rem - {{(RW-RTW-2){1'b0}}, r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_val[k+1] <= r_val[k];
            if (!n_trial[RW-1]) begin
                r_rem[k+1]  <= n_trial;
                r_root[k+1] <= {r_root[k][RTW-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= {r_root[k][RTW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[RTW];
endmodule
